>>> design/sfa_pkg.sv
// sfa_pkg: shared types and constants for soft_float_arith_unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sfa_pkg;
   localparam int MantBits = 64;
   localparam int ExpBits  = 16;

   typedef enum logic [2:0] {
      FUNC_ADD = 3'd0,
      FUNC_SUB = 3'd1,
      FUNC_MUL = 3'd2,
      FUNC_DIV = 3'd3,
      FUNC_I2F = 3'd4,
      FUNC_F2I = 3'd5
   } func_type;

   typedef struct packed {
      logic [2:0]          func;
      logic                a_sign;
      logic [MantBits-1:0] a_mantissa;
      logic signed [ExpBits-1:0] a_exponent;
      logic                b_sign;
      logic [MantBits-1:0] b_mantissa;
      logic signed [ExpBits-1:0] b_exponent;
      logic signed [MantBits-1:0] int_value;
   } req_type;

   typedef struct packed {
      logic                res_sign;
      logic [MantBits-1:0] res_mantissa;
      logic signed [ExpBits-1:0] res_exponent;
      logic signed [MantBits-1:0] int_result;
   } rsp_type;
endpackage
`default_nettype wire

>>> design/soft_float_arith_unit.sv
// soft_float_arith_unit: sign / 64-bit mantissa / 16-bit exponent float ALU.
// Depends on sfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time; req_ready is low while a request is in flight or its response
// waits; the next request can be taken the cycle after the response is accepted. Shifting
// is 1 bit per cycle, and ALIGN, MUL, REM and DIV use one shared 65-bit add/subtract.
// A zero divisor or an undefined code goes straight to the result.
// Reset (synchronous, active high) returns to idle and drops rsp_valid.
module soft_float_arith_unit (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  sfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output sfa_pkg::rsp_type rsp_data
);
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ALIGN = 8'b0000_0010,  // shift operand with the smaller exponent right one bit a cycle
      ST_MUL   = 8'b0000_0100,  // shift-add, 64 steps
      ST_REM   = 8'b0000_1000,  // a % b, 64 steps
      ST_DIV   = 8'b0001_0000,  // restoring quotient, 64 steps
      ST_NORM  = 8'b0010_0000,  // shift left until top bit set or mantissa is zero
      ST_F2I   = 8'b0100_0000,  // exponent-driven shifting
      ST_DONE  = 8'b1000_0000
   } state_type;

   localparam int W = sfa_pkg::MantBits;

   state_type        state_ff, state_in;
   logic [W-1:0]     acc_ff, acc_in;     // result mantissa / product high
   logic [W-1:0]     opa_ff, opa_in;     // multiplier / dividend low bits
   logic [W-1:0]     opb_ff, opb_in;     // multiplicand / divisor / aligned b
   logic [W-1:0]     rem_ff, rem_in;
   logic [15:0]      exp_ff, exp_in;
   logic [15:0]      dist_ff, dist_in;   // remaining shift distance
   logic             sign_ff, sign_in;
   logic             bsign_ff, bsign_in;
   logic             sh_b_ff, sh_b_in;   // align shifts b (else a)
   logic [6:0]       cnt_ff, cnt_in;
   logic [2:0]       func_ff, func_in;
   logic             f2i_neg_ff, f2i_neg_in;
   sfa_pkg::rsp_type out_ff, out_in;
   logic             ov_ff, ov_in;

   // the shared 65-bit add/subtract
   logic [W:0]   alu_x, alu_y, alu_sum;
   logic         alu_sub;
   assign alu_sum = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);

   assign req_ready = (state_ff == ST_IDLE) && !ov_ff;

   always_comb begin
      logic [16:0] ediff;
      state_in   = state_ff;
      acc_in     = acc_ff;
      opa_in     = opa_ff;
      opb_in     = opb_ff;
      rem_in     = rem_ff;
      exp_in     = exp_ff;
      dist_in    = dist_ff;
      sign_in    = sign_ff;
      bsign_in   = bsign_ff;
      sh_b_in    = sh_b_ff;
      cnt_in     = cnt_ff;
      func_in    = func_ff;
      f2i_neg_in = f2i_neg_ff;
      out_in     = out_ff;
      ov_in      = ov_ff;
      alu_x      = '0;
      alu_y      = '0;
      alu_sub    = 1'b0;
      ediff      = '0;

      if (ov_ff && rsp_ready) ov_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               func_in = req_data.func;
               opa_in  = req_data.a_mantissa;
               opb_in  = req_data.b_mantissa;
               sign_in = req_data.a_sign;
               bsign_in = req_data.b_sign ^ (req_data.func == sfa_pkg::FUNC_SUB);
               acc_in  = '0;
               rem_in  = '0;
               cnt_in  = '0;
               unique case (req_data.func) inside
                  sfa_pkg::FUNC_ADD, sfa_pkg::FUNC_SUB: begin
                     ediff = {req_data.a_exponent[15], req_data.a_exponent}
                           - {req_data.b_exponent[15], req_data.b_exponent};
                     if (ediff[16]) begin
                        sh_b_in = 1'b0;
                        exp_in  = req_data.b_exponent;
                        ediff   = 17'd0 - ediff;
                     end else begin
                        sh_b_in = 1'b1;
                        exp_in  = req_data.a_exponent;
                     end
                     dist_in  = (ediff > 17'd64) ? 16'd64 : ediff[15:0];
                     state_in = ST_ALIGN;
                  end
                  sfa_pkg::FUNC_MUL: begin
                     sign_in  = req_data.a_sign ^ req_data.b_sign;
                     exp_in   = req_data.a_exponent + req_data.b_exponent + 16'd64;
                     state_in = ST_MUL;
                  end
                  sfa_pkg::FUNC_DIV: begin
                     sign_in  = req_data.a_sign ^ req_data.b_sign;
                     exp_in   = req_data.a_exponent - req_data.b_exponent - 16'd64;
                     state_in = ST_REM;
                     if (req_data.b_mantissa == '0) begin
                        sign_in  = 1'b0;
                        exp_in   = '0;
                        state_in = ST_DONE;
                     end
                  end
                  sfa_pkg::FUNC_I2F: begin
                     sign_in  = req_data.int_value[W-1];
                     acc_in   = req_data.int_value[W-1] ? (W'(0) - req_data.int_value)
                                                        : req_data.int_value;
                     exp_in   = '0;
                     state_in = ST_NORM;
                  end
                  sfa_pkg::FUNC_F2I: begin
                     acc_in     = req_data.a_mantissa;
                     f2i_neg_in = req_data.a_exponent[15];
                     if (req_data.a_exponent[15]) begin
                        ediff   = 17'd0 - {1'b1, req_data.a_exponent};
                        dist_in = (ediff > 17'd64) ? 16'd64 : ediff[15:0];
                     end else begin
                        dist_in = req_data.a_exponent;
                     end
                     state_in = ST_F2I;
                  end
                  default: begin
                     sign_in  = 1'b0;
                     exp_in   = '0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ALIGN: begin
            if (dist_ff != '0) begin
               if (sh_b_ff) opb_in = opb_ff >> 1;
               else         opa_in = opa_ff >> 1;
               dist_in = dist_ff - 16'd1;
            end else begin
               if (sign_ff == bsign_ff) begin
                  alu_x = {1'b0, opa_ff};
                  alu_y = {1'b0, opb_ff};
                  acc_in = alu_sum[W-1:0];
               end else begin
                  alu_x   = {1'b0, opa_ff};
                  alu_y   = {1'b0, opb_ff};
                  alu_sub = 1'b1;
                  if (!alu_sum[W]) begin
                     acc_in = alu_sum[W-1:0];
                  end else begin
                     acc_in  = opb_ff - opa_ff;
                     sign_in = bsign_ff;
                  end
               end
               state_in = ST_NORM;
            end
         end
         ST_MUL: begin
            // {acc, opa} holds the product; add opb at top when low bit of opa set
            alu_x = {1'b0, acc_ff};
            alu_y = opa_ff[0] ? {1'b0, opb_ff} : '0;
            acc_in = alu_sum[W:1];
            opa_in = {alu_sum[0], opa_ff[W-1:1]};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) state_in = ST_NORM;
         end
         ST_REM: begin
            // rem = a % b, shifting dividend bits in from opa
            alu_x   = {rem_ff, opa_ff[W-1]};
            alu_y   = {1'b0, opb_ff};
            alu_sub = 1'b1;
            rem_in  = alu_sum[W] ? {rem_ff[W-2:0], opa_ff[W-1]} : alu_sum[W-1:0];
            opa_in  = opa_ff << 1;
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            alu_x   = {rem_ff, 1'b0};
            alu_y   = {1'b0, opb_ff};
            alu_sub = 1'b1;
            if (!alu_sum[W]) begin
               rem_in = alu_sum[W-1:0];
               acc_in = {acc_ff[W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[W-2:0], 1'b0};
               acc_in = {acc_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) state_in = ST_NORM;
         end
         ST_NORM: begin
            if (acc_ff != '0 && !acc_ff[W-1]) begin
               acc_in = acc_ff << 1;
               exp_in = exp_ff - 16'd1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_F2I: begin
            if (f2i_neg_ff) begin
               if (dist_ff != '0) begin
                  acc_in  = acc_ff >> 1;
                  dist_in = dist_ff - 16'd1;
               end else state_in = ST_DONE;
            end else if (dist_ff != '0 && acc_ff != '0 && !acc_ff[W-1]) begin
               acc_in  = acc_ff << 1;
               dist_in = dist_ff - 16'd1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            out_in = '0;
            if (func_ff == sfa_pkg::FUNC_F2I) begin
               out_in.int_result = sign_ff ? (W'(0) - acc_ff) : acc_ff;
            end else if (func_ff <= sfa_pkg::FUNC_I2F) begin
               out_in.res_sign     = sign_ff;
               out_in.res_mantissa = acc_ff;
               out_in.res_exponent = exp_ff;
            end
            ov_in    = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      acc_ff     <= acc_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      rem_ff     <= rem_in;
      exp_ff     <= exp_in;
      dist_ff    <= dist_in;
      sign_ff    <= sign_in;
      bsign_ff   <= bsign_in;
      sh_b_ff    <= sh_b_in;
      cnt_ff     <= cnt_in;
      func_ff    <= func_in;
      f2i_neg_ff <= f2i_neg_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire
